// ----- hw/rtl/lcabl_pkg.sv -----
// lcabl_pkg: sizes, item codes and index helpers for the lca binary lifting block
// used by lca_binary_lifting; depends on nothing
`timescale 1ns / 1ps

package lcabl_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 11;

  localparam int NODE_W = 11;
  localparam int MODE_W = 2;
  localparam int IDX_W  = $clog2(MAX_NODES + 1);
  localparam int LVL_W  = $clog2(LEVELS);

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam lvl_t LVL_TOP  = LVL_W'(LEVELS - 1);
  localparam idx_t IDX_LAST = IDX_W'(MAX_NODES);

  // out-of-range node numbers map to node 0
  function automatic idx_t to_index(node_t v);
    return (v > MAX_NODES) ? '0 : idx_t'(v);
  endfunction

  function automatic idx_t build_last(node_t cnt);
    return (cnt > MAX_NODES) ? IDX_LAST : idx_t'(cnt);
  endfunction

endpackage

// ----- hw/rtl/lca_binary_lifting.sv -----
// lca_binary_lifting: lowest common ancestor unit, binary lifting over a jump table
// holds the jump table and depth memories and the sequencer; depends on lcabl_pkg
`timescale 1ns / 1ps
//
//  channel  signals                              direction  transaction
//  in       in_valid in_ready mode node_a        input      one load, build or query item
//           node_b node_level
//  out      out_valid out_ready ancestor         output     one result per item
//           is_answer
//  cfg      cfg_valid cfg_ready cfg_data         input      write of node_count
//
//  a load writes its entries when accepted; a query does one memory read per step, and each
//  lift taken costs a table read plus a dependent depth read; descent compares one level a step
//  a build writes (LEVELS-1) * min(node_count, MAX_NODES) entries, each with two dependent
//  table reads followed by a write on the single write port
//  after reset a clearing pass zeroes all LEVELS * (MAX_NODES+1) = 11275 table entries and
//  the depth memory; in_ready stays low meanwhile, cfg writes are taken at any time
//  a finished result waits in the output register; in_ready is high whenever idle

module lca_binary_lifting (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lcabl_pkg::MODE_W-1:0]  mode,
  input  logic [lcabl_pkg::NODE_W-1:0]  node_a,
  input  logic [lcabl_pkg::NODE_W-1:0]  node_b,
  input  logic [lcabl_pkg::NODE_W-1:0]  node_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcabl_pkg::NODE_W-1:0]  ancestor,
  output logic                          is_answer,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcabl_pkg::NODE_W-1:0]  cfg_data
);
  import lcabl_pkg::*;

  typedef enum logic [3:0] {
    CLEAR, IDLE, Q_RDA, Q_RDB, Q_SWAP, L_CHK, L_HOP, L_DEPW,
    L_END, D_CMP, F_WAIT, B_RD1, B_RD2, B_WR, DONE
  } state_t;

  state_t state;

  node_t node_count;
  idx_t  a, b, j, last, result;
  node_t da, db;
  lvl_t  lvl;
  logic  is_q;

  // memories
  idx_t  jt [LEVELS][MAX_NODES+1];
  node_t dm [MAX_NODES+1];

  logic  jt_we, dm_we;
  lvl_t  jt_wl, ra_l, rb_l;
  idx_t  jt_wn, jt_wd, ra_n, rb_n, dm_wa, dm_ra;
  node_t dm_wd;
  idx_t  jt_rd_a, jt_rd_b;
  node_t dm_rd;

  logic        accept;
  idx_t        ld_idx;
  logic        load_ok;
  logic [NODE_W:0] diff;
  logic        take;
  logic        differ;
  idx_t        a_next, b_next;
  lvl_t        lvl_dn;

  assign in_ready = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign ld_idx = to_index(node_a);
  assign load_ok = accept && (mode == MODE_LOAD) && (ld_idx != '0);

  // lift step taken while 2^lvl does not exceed the signed depth difference
  assign diff = {1'b0, da} - {1'b0, db};
  assign take = !diff[NODE_W] && ((diff >> lvl) != '0);

  assign differ = (jt_rd_a != jt_rd_b);
  assign a_next = differ ? jt_rd_a : a;
  assign b_next = differ ? jt_rd_b : b;
  assign lvl_dn = (lvl == '0) ? '0 : lvl - 1'b1;

  always_comb begin
    jt_we = 1'b0;
    jt_wl = lvl;
    jt_wn = j;
    jt_wd = '0;
    ra_l  = lvl;
    ra_n  = a;
    rb_l  = lvl;
    rb_n  = b;
    dm_we = 1'b0;
    dm_wa = j;
    dm_wd = '0;
    dm_ra = a;
    case (state)
      CLEAR: begin
        jt_we = 1'b1;
        dm_we = (lvl == '0);
      end
      IDLE: begin
        if (load_ok) begin
          jt_we = 1'b1;
          jt_wl = '0;
          jt_wn = ld_idx;
          jt_wd = to_index(node_b);
          dm_we = 1'b1;
          dm_wa = ld_idx;
          dm_wd = node_level;
        end
      end
      Q_RDA: dm_ra = a;
      Q_RDB: dm_ra = b;
      L_HOP: dm_ra = jt_rd_a;
      L_END: begin
        ra_l = LVL_TOP;
        rb_l = LVL_TOP;
      end
      D_CMP: begin
        ra_l = lvl_dn;
        rb_l = lvl_dn;
        ra_n = a_next;
        rb_n = b_next;
      end
      B_RD1: begin
        ra_l = lvl - 1'b1;
        ra_n = j;
      end
      B_RD2: begin
        ra_l = lvl - 1'b1;
        ra_n = jt_rd_a;
      end
      B_WR: begin
        jt_we = 1'b1;
        jt_wd = jt_rd_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (jt_we) begin
      jt[jt_wl][jt_wn] <= jt_wd;
    end
    jt_rd_a <= jt[ra_l][ra_n];
    jt_rd_b <= jt[rb_l][rb_n];
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm[dm_wa] <= dm_wd;
    end
    dm_rd <= dm[dm_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      lvl        <= '0;
      j          <= '0;
      node_count <= NODE_W'(1);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      if (out_valid && out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          if (j == IDX_LAST) begin
            j <= '0;
            if (lvl == LVL_TOP) begin
              state <= IDLE;
            end else begin
              lvl <= lvl + 1'b1;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        IDLE: begin
          if (accept) begin
            result <= '0;
            is_q   <= 1'b0;
            case (mode)
              MODE_BUILD: begin
                last <= build_last(node_count);
                lvl  <= lvl_t'(1);
                j    <= idx_t'(1);
                state <= (build_last(node_count) == '0) ? DONE : B_RD1;
              end
              MODE_QUERY: begin
                a     <= to_index(node_a);
                b     <= to_index(node_b);
                is_q  <= 1'b1;
                state <= Q_RDA;
              end
              default: state <= DONE;
            endcase
          end
        end
        Q_RDA: state <= Q_RDB;
        Q_RDB: begin
          da    <= dm_rd;
          state <= Q_SWAP;
        end
        Q_SWAP: begin
          // deeper node goes to a
          if (da < dm_rd) begin
            a  <= b;
            b  <= a;
            da <= dm_rd;
            db <= da;
          end else begin
            db <= dm_rd;
          end
          lvl   <= LVL_TOP;
          state <= L_CHK;
        end
        L_CHK: begin
          if (take) begin
            state <= L_HOP;
          end else if (lvl == '0) begin
            state <= L_END;
          end else begin
            lvl <= lvl - 1'b1;
          end
        end
        L_HOP: begin
          a     <= jt_rd_a;
          state <= L_DEPW;
        end
        L_DEPW: begin
          da <= dm_rd;
          if (lvl == '0) begin
            state <= L_END;
          end else begin
            lvl   <= lvl - 1'b1;
            state <= L_CHK;
          end
        end
        L_END: begin
          if (a == b) begin
            result <= a;
            state  <= DONE;
          end else begin
            lvl   <= LVL_TOP;
            state <= D_CMP;
          end
        end
        D_CMP: begin
          a <= a_next;
          b <= b_next;
          if (lvl == '0) begin
            state <= F_WAIT;
          end else begin
            lvl <= lvl - 1'b1;
          end
        end
        F_WAIT: begin
          result <= jt_rd_a;
          state  <= DONE;
        end
        B_RD1: state <= B_RD2;
        B_RD2: state <= B_WR;
        B_WR: begin
          if (j == last) begin
            j <= idx_t'(1);
            if (lvl == LVL_TOP) begin
              state <= DONE;
            end else begin
              lvl   <= lvl + 1'b1;
              state <= B_RD1;
            end
          end else begin
            j     <= j + 1'b1;
            state <= B_RD1;
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            ancestor  <= NODE_W'(result);
            is_answer <= is_q;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
